FILE: design/htl_pkg.sv
// Shared types and constants for the Huffman tree load and decode block.
package htl_pkg;

  // Input command codes
  localparam logic [1:0] CMD_CONTINUE = 2'd0;
  localparam logic [1:0] CMD_LOAD     = 2'd1;
  localparam logic [1:0] CMD_RESTART  = 2'd2;

  // Default node store depth
  localparam int NODE_COUNT_DEF = 1024;

  // Most symbols per byte, last bit index, symbol bits owed after a leaf flag
  localparam int          MAX_SYMS  = 8;
  localparam logic [2:0]  LAST_BIT  = 3'd7;
  localparam logic [3:0]  SYM_BITS  = 4'd8;
  localparam int          CNT_W     = 4;

  // Queue depths
  localparam int IN_DEPTH   = 2;
  localparam int SYM_DEPTH  = 16;
  localparam int DESC_DEPTH = 2;

  // Classified input item
  typedef struct packed {
    logic       start_load;
    logic       restart;
    logic [7:0] data;
  } in_item_t;

  // Per-byte result descriptor
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ready;
    logic             err;
  } res_desc_t;

  // Core to result queue traffic
  typedef struct packed {
    logic      sym_push;
    logic [7:0] sym;
    logic      desc_push;
    res_desc_t desc;
  } core_out_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOAD,
    PH_DECODE
  } phase_t;

  typedef enum logic [1:0] {
    CS_WAIT,
    CS_BITS,
    CS_DONE
  } core_state_t;

endpackage

FILE: design/huffman_tree_load_and_decode.sv
// Top level: Huffman preorder tree loader and decoder.
//
//  channel   signals                                      handshake
//  input     command, data_byte                           push / full
//  result    symbol, symbol_valid, last, tree_ready,      empty / pop
//            tree_error
//  config    cfg_data (bit_order)                         cfg_valid / cfg_ready
//
// In the bit engine each byte is taken from the input queue, then stepped
// bit by bit (one node-store access each), and a final step settles the last read.
// Results of a byte appear together once the byte is done; an empty byte gives
// one result with symbol_valid low. A byte starts only when the result queue
// holds room for eight more symbols. Reset (rst, synchronous) clears all
// control state; the node store needs no clearing pass.
module huffman_tree_load_and_decode #(
  parameter int NODE_COUNT = htl_pkg::NODE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] symbol,
  output logic       symbol_valid,
  output logic       last,
  output logic       tree_ready,
  output logic       tree_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import htl_pkg::*;

  logic      avail;
  in_item_t  item;
  logic      take;
  logic      room;
  core_out_t co;

  htl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .data_byte (data_byte),
    .avail     (avail),
    .item      (item),
    .take      (take)
  );

  htl_core #(
    .NODE_COUNT (NODE_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .avail     (avail),
    .item      (item),
    .take      (take),
    .room      (room),
    .co        (co)
  );

  htl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .co           (co),
    .room         (room),
    .empty        (empty),
    .pop          (pop),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .last         (last),
    .tree_ready   (tree_ready),
    .tree_error   (tree_error)
  );

endmodule

FILE: design/htl_front.sv
// Input queue: accepts and classifies command/byte transactions.
module htl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      command,
  input  logic [7:0]      data_byte,
  output logic            avail,
  output htl_pkg::in_item_t item,
  input  logic            take
);
  import htl_pkg::*;

  localparam int PW = $clog2(IN_DEPTH);

  in_item_t      q_mem [IN_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;
  in_item_t      cls;

  assign full    = (count == (PW+1)'(IN_DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = take && avail;
  assign item    = q_mem[rd_ptr];

  // Classify command; the unused code acts as continue
  always_comb begin
    cls.start_load = (command == CMD_LOAD);
    cls.restart    = (command == CMD_RESTART);
    cls.data       = data_byte;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr] <= cls;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(IN_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(IN_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/htl_back.sv
// Result queue: symbol FIFO plus per-byte descriptors, drained by pop.
module htl_back (
  input  logic              clk,
  input  logic              rst,
  input  htl_pkg::core_out_t co,
  output logic              room,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        symbol,
  output logic              symbol_valid,
  output logic              last,
  output logic              tree_ready,
  output logic              tree_error
);
  import htl_pkg::*;

  localparam int SPW = $clog2(SYM_DEPTH);
  localparam int DPW = $clog2(DESC_DEPTH);

  logic [7:0]       sym_mem [SYM_DEPTH];
  logic [SPW-1:0]   s_wr;
  logic [SPW-1:0]   s_rd;
  logic [SPW:0]     s_count;
  res_desc_t        desc_mem [DESC_DEPTH];
  logic [DPW-1:0]   d_wr;
  logic [DPW-1:0]   d_rd;
  logic [DPW:0]     d_count;
  logic [CNT_W-1:0] idx;
  res_desc_t        head;
  logic             head_last;
  logic             do_pop;
  logic             sym_pop;
  logic             desc_pop;

  // Room for a whole byte's worth of results
  assign room = (s_count <= (SPW+1)'(SYM_DEPTH - MAX_SYMS)) &&
                (d_count != (DPW+1)'(DESC_DEPTH));

  // Head of queue and pop decode
  assign head      = desc_mem[d_rd];
  assign empty     = (d_count == '0);
  assign head_last = (head.count == '0) || (idx == head.count - 1'b1);
  assign do_pop    = pop && !empty;
  assign sym_pop   = do_pop && (head.count != '0);
  assign desc_pop  = do_pop && head_last;

  // Result ports
  assign symbol       = (head.count == '0) ? 8'd0 : sym_mem[s_rd];
  assign symbol_valid = (head.count != '0);
  assign last         = head_last;
  assign tree_ready   = head.ready;
  assign tree_error   = head.err;

  // Storage
  always_ff @(posedge clk) begin
    if (co.sym_push)  sym_mem[s_wr]  <= co.sym;
    if (co.desc_push) desc_mem[d_wr] <= co.desc;
  end

  // Pointers, counts and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      s_wr    <= '0;
      s_rd    <= '0;
      s_count <= '0;
      d_wr    <= '0;
      d_rd    <= '0;
      d_count <= '0;
      idx     <= '0;
    end else begin
      if (co.sym_push) s_wr <= (s_wr == SPW'(SYM_DEPTH-1)) ? '0 : s_wr + 1'b1;
      if (sym_pop)     s_rd <= (s_rd == SPW'(SYM_DEPTH-1)) ? '0 : s_rd + 1'b1;
      if (co.sym_push && !sym_pop)      s_count <= s_count + 1'b1;
      else if (!co.sym_push && sym_pop) s_count <= s_count - 1'b1;

      if (co.desc_push) d_wr <= (d_wr == DPW'(DESC_DEPTH-1)) ? '0 : d_wr + 1'b1;
      if (desc_pop)     d_rd <= (d_rd == DPW'(DESC_DEPTH-1)) ? '0 : d_rd + 1'b1;
      if (co.desc_push && !desc_pop)      d_count <= d_count + 1'b1;
      else if (!co.desc_push && desc_pop) d_count <= d_count - 1'b1;

      if (desc_pop)    idx <= '0;
      else if (do_pop) idx <= idx + 1'b1;
    end
  end

endmodule

FILE: design/htl_core.sv
// Bit engine: tree loader and tree walker over the node store, one bit a cycle once a byte is taken.
module htl_core #(
  parameter int NODE_COUNT = htl_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               avail,
  input  htl_pkg::in_item_t  item,
  output logic               take,
  input  logic               room,
  output htl_pkg::core_out_t co
);
  import htl_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  // Node store, split by field so each field writes alone
  logic          leaf_mem [NODE_COUNT];
  logic [7:0]    sym_mem  [NODE_COUNT];
  logic [AW:0]   one_mem  [NODE_COUNT];
  logic [AW-1:0] stk_mem  [NODE_COUNT];

  logic          leaf_q;
  logic [7:0]    sym_q;
  logic [AW:0]   one_q;
  logic [AW-1:0] stk_q;

  // Memory port controls
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          leaf_we;
  logic          leaf_wd;
  logic [AW-1:0] node_waddr;
  logic          sym_we;
  logic [AW-1:0] sym_waddr;
  logic [7:0]    sym_wd;
  logic          one_we;
  logic [AW-1:0] one_waddr;
  logic [AW:0]   one_wd;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [AW-1:0] stk_wd;
  logic          stk_re;
  logic [AW-1:0] stk_raddr;

  // Control state
  core_state_t      state, state_next;
  logic [2:0]       bit_idx;
  logic [7:0]       byte_q;
  logic             bit_order;
  phase_t           phase, phase_next;
  logic             err, err_next;
  logic [AW:0]      nfree, nfree_next;
  logic [AW:0]      depth, depth_next;
  logic [AW-1:0]    tos, tos_next;
  logic             refill, refill_next;
  logic [3:0]       owed, owed_next;
  logic [7:0]       lc_val, lc_val_next;
  logic [AW-1:0]    cur, cur_next;
  logic [AW:0]      cur_one, cur_one_next;
  logic             pend, pend_next;
  logic [AW:0]      root_one;
  logic [CNT_W-1:0] sym_cnt, sym_cnt_next;

  logic          bit_step;
  logic          finish;
  logic          b;
  logic [AW-1:0] eff_cur;
  logic [AW:0]   eff_one;
  logic [AW:0]   nxt;
  logic [7:0]    val;
  logic [3:0]    owed_dec;

  assign cfg_ready = 1'b1;

  // Current stream bit
  assign b = bit_order ? byte_q[LAST_BIT - bit_idx] : byte_q[bit_idx];

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      CS_WAIT: if (avail && room) state_next = CS_BITS;
      CS_BITS: if (bit_idx == LAST_BIT) state_next = CS_DONE;
      CS_DONE: state_next = CS_WAIT;
      default: state_next = CS_WAIT;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    take     = 1'b0;
    bit_step = 1'b0;
    finish   = 1'b0;
    case (state)
      CS_WAIT: take     = avail && room;
      CS_BITS: bit_step = 1'b1;
      CS_DONE: finish   = 1'b1;
      default: ;
    endcase
  end

  // Datapath: command effects, load and decode steps
  always_comb begin
    phase_next   = phase;
    err_next     = err;
    nfree_next   = nfree;
    depth_next   = depth;
    tos_next     = refill ? stk_q : tos;
    refill_next  = 1'b0;
    owed_next    = owed;
    lc_val_next  = lc_val;
    cur_next     = cur;
    cur_one_next = cur_one;
    pend_next    = pend;
    sym_cnt_next = sym_cnt;
    rd_en      = 1'b0;
    raddr      = '0;
    leaf_we    = 1'b0;
    leaf_wd    = 1'b0;
    node_waddr = nfree[AW-1:0];
    sym_we     = 1'b0;
    sym_waddr  = nfree[AW-1:0];
    sym_wd     = 8'd0;
    one_we     = 1'b0;
    one_waddr  = nfree[AW-1:0];
    one_wd     = '0;
    stk_we     = 1'b0;
    stk_waddr  = depth[AW-1:0];
    stk_wd     = nfree[AW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = '0;
    co         = '0;
    eff_cur    = cur;
    eff_one    = cur_one;
    nxt        = '0;
    val        = {lc_val[6:0], b};
    owed_dec   = owed - 1'b1;

    // Byte start: apply command
    if (take) begin
      sym_cnt_next = '0;
      if (item.start_load) begin
        nfree_next   = '0;
        depth_next   = '0;
        owed_next    = '0;
        lc_val_next  = '0;
        cur_next     = '0;
        cur_one_next = root_one;
        phase_next   = PH_LOAD;
      end else if (item.restart) begin
        cur_next     = '0;
        cur_one_next = root_one;
      end
    end

    // Settle the node read issued last cycle
    if ((bit_step || finish) && pend) begin
      pend_next = 1'b0;
      if (leaf_q) begin
        co.sym_push  = 1'b1;
        co.sym       = sym_q;
        sym_cnt_next = sym_cnt + 1'b1;
        eff_cur      = '0;
        eff_one      = root_one;
      end else begin
        eff_one      = one_q;
      end
      cur_next     = eff_cur;
      cur_one_next = eff_one;
    end

    if (bit_step) begin
      case (phase)
        PH_LOAD: begin
          if (owed != 4'd0) begin
            // Gathering symbol bits of a leaf
            owed_next   = owed_dec;
            lc_val_next = val;
            if (owed_dec == 4'd0) begin
              sym_we      = (nfree != '0);
              sym_waddr   = AW'(nfree - 1'b1);
              sym_wd      = val;
              owed_next   = '0;
              lc_val_next = '0;
              if (depth == '0) begin
                if (nfree <= (AW+1)'(1)) begin
                  err_next   = 1'b1;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next   = PH_DECODE;
                  cur_next     = '0;
                  cur_one_next = root_one;
                end
              end else begin
                // Pop: link the pending node's one child
                depth_next = depth - 1'b1;
                one_we     = 1'b1;
                one_waddr  = tos;
                one_wd     = nfree;
                if (depth >= (AW+1)'(2)) begin
                  stk_re      = 1'b1;
                  stk_raddr   = AW'(depth - (AW+1)'(2));
                  refill_next = 1'b1;
                end
              end
            end
          end else if (nfree >= (AW+1)'(NODE_COUNT)) begin
            err_next   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            // New node
            nfree_next = nfree + 1'b1;
            leaf_we    = 1'b1;
            leaf_wd    = b;
            sym_we     = 1'b1;
            one_we     = 1'b1;
            if (b) begin
              owed_next = SYM_BITS;
            end else begin
              stk_we     = 1'b1;
              depth_next = depth + 1'b1;
              tos_next   = nfree[AW-1:0];
            end
          end
        end
        PH_DECODE: begin
          nxt = b ? eff_one : ({1'b0, eff_cur} + (AW+1)'(1));
          if (nxt >= (AW+1)'(NODE_COUNT)) nxt = '0;
          rd_en     = 1'b1;
          raddr     = nxt[AW-1:0];
          cur_next  = nxt[AW-1:0];
          pend_next = 1'b1;
        end
        default: ;
      endcase
    end

    // Byte end: descriptor for the result queue
    if (finish) begin
      co.desc_push  = 1'b1;
      co.desc.count = sym_cnt_next;
      co.desc.ready = (phase == PH_DECODE);
      co.desc.err   = err;
    end
  end

  // Node store
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[node_waddr] <= leaf_wd;
    if (rd_en)   leaf_q <= leaf_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= sym_wd;
    if (rd_en)  sym_q <= sym_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (one_we) one_mem[one_waddr] <= one_wd;
    if (rd_en)  one_q <= one_mem[raddr];
  end

  // Pending stack, top held in tos
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_WAIT;
      bit_idx   <= '0;
      bit_order <= 1'b1;
      phase     <= PH_IDLE;
      err       <= 1'b0;
      nfree     <= '0;
      depth     <= '0;
      refill    <= 1'b0;
      owed      <= '0;
      lc_val    <= '0;
      cur       <= '0;
      cur_one   <= '0;
      pend      <= 1'b0;
      root_one  <= '0;
      sym_cnt   <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      err     <= err_next;
      nfree   <= nfree_next;
      depth   <= depth_next;
      refill  <= refill_next;
      owed    <= owed_next;
      lc_val  <= lc_val_next;
      cur     <= cur_next;
      cur_one <= cur_one_next;
      pend    <= pend_next;
      sym_cnt <= sym_cnt_next;
      if (take)          bit_idx <= '0;
      else if (bit_step) bit_idx <= bit_idx + 1'b1;
      if (cfg_valid) bit_order <= cfg_data;
      if (one_we && (one_waddr == '0)) root_one <= one_wd;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (take) byte_q <= item.data;
  end

endmodule
